FILE: rtl/slot_alloc_pkg.sv
`default_nettype none

package slot_alloc_pkg;

  // Pool size and the widths that follow from it.
  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Operation codes carried on the kind field.
  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_UPDATE  = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

endpackage

`default_nettype wire

FILE: rtl/slot_alloc_ram.sv
`default_nettype none

module slot_alloc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/slot_allocator_with_live_map.sv
// Slot allocator with a live map over a pool of SLOTS slots.
// Command channel: a beat is taken at a rising edge where start is high and
// busy is low. kind_i selects insert (grant a free slot), update (mark
// slot_in_i live) or release (free slot_in_i). Freed slots go on a LIFO
// stack and are reused first; otherwise the high-water slot is granted.
// Result channel: done_o is high for exactly one cycle per command, after the
// accept passes x_valid_q and done_q, with slot_out_o and status_o. The count
// outputs live_total_o, slots_used_o and free_total_o show the state after
// the most recent command and are valid whenever done_o is high.
// Throughput is one command per cycle. The live map and the free stack sit
// in RAMs with a registered read; the read for a command is issued in the
// cycle it is accepted, using the state that the command ahead of it is
// producing, and a write to the same live entry in that cycle is forwarded.
// The stack top is held in a register, and the entry below it is read
// ahead so that pops can follow each other every cycle.
// After reset busy stays high while the live map is swept to zero, from
// slot 0 up to SLOTS-1; no command is taken in that time. The receiver cannot
// stall, so done_o never waits.
`default_nettype none

module slot_allocator_with_live_map (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            kind_i,
  input  wire slot_alloc_pkg::slot_t slot_in_i,
  output logic                       done_o,
  output slot_alloc_pkg::slot_t      slot_out_o,
  output logic [1:0]                 status_o,
  output slot_alloc_pkg::cnt_t       live_total_o,
  output slot_alloc_pkg::cnt_t       slots_used_o,
  output slot_alloc_pkg::cnt_t       free_total_o
);

  import slot_alloc_pkg::*;

  // Control state.
  logic    clr_busy_q;
  slot_t   clr_addr_q;
  logic    x_valid_q;
  logic    done_q;
  logic    fwd_hit_q, fwd_hit_d;
  logic    fwd_val_q;
  cnt_t    depth_q, depth_d;
  cnt_t    hw_q, hw_d;
  cnt_t    cnt_q, cnt_d;

  // Payload registers.
  logic [1:0] x_kind_q;
  slot_t      x_slot_q;
  slot_t      top_q, top_d;
  slot_t      slot_out_q;
  status_e    status_q;

  // Execute stage outputs.
  slot_t   res_slot;
  status_e res_status;
  logic    live_bit;
  logic    slot_ok;
  logic    mark;
  logic    live_we;
  slot_t   live_wa;
  logic    live_wd;
  logic    stk_we;
  slot_t   stk_wa;
  slot_t   stk_wd;

  // RAM ports.
  logic    accept;
  slot_t   ins_tgt;
  slot_t   live_ra;
  logic    live_rdata;
  logic    lram_we;
  slot_t   lram_wa;
  logic    lram_wd;
  cnt_t    stk_below;
  slot_t   stk_ra;
  slot_t   stk_rdata;

  assign accept = start && !busy;
  assign busy   = clr_busy_q;

  // Live bit of the command in execute, with the write of the previous
  // command forwarded when it hit the same entry.
  assign live_bit = fwd_hit_q ? fwd_val_q : live_rdata;
  assign slot_ok  = cnt_t'(x_slot_q) < cnt_t'(SLOTS);

  // Execute stage: one command against the registered state.
  always_comb begin
    depth_d    = depth_q;
    hw_d       = hw_q;
    cnt_d      = cnt_q;
    top_d      = top_q;
    res_slot   = x_slot_q;
    res_status = ST_OK;
    mark       = 1'b0;
    live_we    = 1'b0;
    live_wa    = x_slot_q;
    live_wd    = 1'b0;
    stk_we     = 1'b0;
    stk_wa     = depth_q[SLOT_W-1:0];
    stk_wd     = x_slot_q;
    if (x_valid_q) begin
      case (x_kind_q)
        KIND_INSERT: begin
          if (depth_q != '0) begin
            depth_d  = depth_q - cnt_t'(1);
            res_slot = top_q;
            top_d    = stk_rdata;
            live_wa  = top_q;
            mark     = 1'b1;
          end else if (hw_q < cnt_t'(SLOTS)) begin
            res_slot = hw_q[SLOT_W-1:0];
            hw_d     = hw_q + cnt_t'(1);
            live_wa  = hw_q[SLOT_W-1:0];
            mark     = 1'b1;
          end else begin
            res_slot   = '0;
            res_status = ST_FULL;
          end
        end
        KIND_UPDATE: begin
          if (slot_ok) begin
            if (cnt_t'(x_slot_q) >= hw_q) begin
              hw_d = cnt_t'(x_slot_q) + cnt_t'(1);
            end
            mark = 1'b1;
          end else begin
            res_status = ST_FULL;
          end
        end
        KIND_RELEASE: begin
          if (slot_ok && live_bit) begin
            live_we = 1'b1;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - cnt_t'(1);
            end
            if (depth_q < cnt_t'(SLOTS)) begin
              stk_we  = 1'b1;
              depth_d = depth_q + cnt_t'(1);
              top_d   = x_slot_q;
            end else begin
              res_status = ST_OVERFLOW;
            end
          end else begin
            res_status = ST_NOT_LIVE;
          end
        end
        default: begin
        end
      endcase
      // Marking a slot live only writes and counts when it was not live.
      if (mark && !live_bit) begin
        live_we = 1'b1;
        live_wd = 1'b1;
        cnt_d   = cnt_q + cnt_t'(1);
      end
    end
  end

  // Read addresses for the next command, taken from the state being made.
  assign ins_tgt   = (depth_d != '0) ? top_d : hw_d[SLOT_W-1:0];
  assign live_ra   = (kind_i == KIND_INSERT) ? ins_tgt : slot_in_i;
  assign stk_below = depth_d - cnt_t'(2);
  assign stk_ra    = stk_below[SLOT_W-1:0];
  assign fwd_hit_d = accept && live_we && (live_wa == live_ra);

  // The clearing sweep owns the live map write port after reset.
  assign lram_we = clr_busy_q || live_we;
  assign lram_wa = clr_busy_q ? clr_addr_q : live_wa;
  assign lram_wd = clr_busy_q ? 1'b0 : live_wd;

  slot_alloc_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (lram_we),
    .waddr_i (lram_wa),
    .wdata_i (lram_wd),
    .raddr_i (live_ra),
    .rdata_o (live_rdata)
  );

  slot_alloc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_wa),
    .wdata_i (stk_wd),
    .raddr_i (stk_ra),
    .rdata_o (stk_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      x_valid_q  <= 1'b0;
      done_q     <= 1'b0;
      fwd_hit_q  <= 1'b0;
      depth_q    <= '0;
      hw_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + slot_t'(1);
        if (clr_addr_q == slot_t'(SLOTS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      x_valid_q <= accept;
      done_q    <= x_valid_q;
      fwd_hit_q <= fwd_hit_d;
      depth_q   <= depth_d;
      hw_q      <= hw_d;
      cnt_q     <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_kind_q   <= kind_i;
    x_slot_q   <= slot_in_i;
    fwd_val_q  <= live_wd;
    top_q      <= top_d;
    slot_out_q <= res_slot;
    status_q   <= res_status;
  end

  assign done_o       = done_q;
  assign slot_out_o   = slot_out_q;
  assign status_o     = status_q;
  assign live_total_o = cnt_q;
  assign slots_used_o = hw_q;
  assign free_total_o = depth_q;

endmodule

`default_nettype wire

FILE: rtl/slot_alloc_chk.sv
`default_nettype none

module slot_alloc_chk (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done_o,
  input wire logic [1:0]            status_o,
  input wire slot_alloc_pkg::cnt_t  live_total_o,
  input wire slot_alloc_pkg::cnt_t  slots_used_o,
  input wire slot_alloc_pkg::cnt_t  free_total_o
);

  import slot_alloc_pkg::*;

  // Every accepted command yields a result beat on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted command produced no result");

  // No result appears without a command behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without accepted command");

  // The live count never exceeds the high-water mark, as live slots lie below it.
  a_live_below_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (live_total_o <= slots_used_o))
    else $error("live count above high-water mark");

  // A refused command leaves every count as it was.
  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) && (status_o == ST_FULL || status_o == ST_NOT_LIVE))
    |-> (live_total_o == $past(live_total_o) && slots_used_o == $past(slots_used_o)
         && free_total_o == $past(free_total_o)))
    else $error("refused command changed the counts");

endmodule

bind slot_allocator_with_live_map slot_alloc_chk u_slot_alloc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .live_total_o (live_total_o),
  .slots_used_o (slots_used_o),
  .free_total_o (free_total_o)
);

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import slot_alloc_pkg::*;

  // Kind code that the block treats as a no-op echo.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned QUEUE_ROOM  = 4;

  typedef struct packed {
    logic [1:0] kind;
    slot_t      slot;
  } alloc_cmd_t;

  typedef struct packed {
    slot_t      slot;
    logic [1:0] status;
    cnt_t       live;
    cnt_t       used;
    cnt_t       free;
  } alloc_result_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       start     = 1'b0;
  logic [1:0] kind_i    = KIND_INSERT;
  slot_t      slot_in_i = '0;
  logic       busy;
  logic       done_o;
  slot_t      slot_out_o;
  logic [1:0] status_o;
  cnt_t       live_total_o;
  cnt_t       slots_used_o;
  cnt_t       free_total_o;

  slot_allocator_with_live_map u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .slot_in_i    (slot_in_i),
    .done_o       (done_o),
    .slot_out_o   (slot_out_o),
    .status_o     (status_o),
    .live_total_o (live_total_o),
    .slots_used_o (slots_used_o),
    .free_total_o (free_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the allocator state, advanced once per accepted beat.
  bit    live_bits [SLOTS];
  slot_t freed_slots [SLOTS];
  int    freed_depth = 0;
  int    water_mark  = 0;
  int    live_cnt    = 0;
  slot_t last_grant  = '0;

  alloc_cmd_t    cmd_q [$];
  alloc_result_t grant_q [$];
  int            queued_cnt   = 0;
  int            accepted_cnt = 0;
  int            errors       = 0;
  int            sender_idle_pct = 0;
  int            quiet_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d (beat %0d)", what, got, want,
             accepted_cnt);
    errors++;
  endtask

  task automatic mark_slot_live(input slot_t s);
    if (!live_bits[s]) begin
      live_bits[s] = 1'b1;
      live_cnt++;
    end
  endtask

  // Applies one command to the shadow state and returns the result it yields.
  task automatic allocate_step(input alloc_cmd_t cmd, output alloc_result_t res);
    slot_t      grant;
    logic [1:0] status;
    grant  = cmd.slot;
    status = ST_OK;
    case (cmd.kind)
      KIND_INSERT: begin
        if (freed_depth > 0) begin
          freed_depth--;
          grant = freed_slots[freed_depth];
          mark_slot_live(grant);
        end else if (water_mark < SLOTS) begin
          grant = slot_t'(water_mark);
          water_mark++;
          mark_slot_live(grant);
        end else begin
          grant  = '0;
          status = ST_FULL;
        end
        last_grant = grant;
      end
      KIND_UPDATE: begin
        if (int'(cmd.slot) >= water_mark) water_mark = int'(cmd.slot) + 1;
        mark_slot_live(cmd.slot);
      end
      KIND_RELEASE: begin
        if (live_bits[cmd.slot]) begin
          live_bits[cmd.slot] = 1'b0;
          if (live_cnt > 0) live_cnt--;
          if (freed_depth < SLOTS) begin
            freed_slots[freed_depth] = cmd.slot;
            freed_depth++;
          end else begin
            status = ST_OVERFLOW;
          end
        end else begin
          status = ST_NOT_LIVE;
        end
      end
      default: ;
    endcase
    res.slot   = grant;
    res.status = status;
    res.live   = cnt_t'(live_cnt);
    res.used   = cnt_t'(water_mark);
    res.free   = cnt_t'(freed_depth);
  endtask

  // Driver: offers the next pending command whenever the previous beat is gone.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (cmd_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        alloc_cmd_t nxt;
        nxt = cmd_q.pop_front();
        start     <= 1'b1;
        kind_i    <= nxt.kind;
        slot_in_i <= nxt.slot;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat, then predicts for a newly accepted command.
  always @(posedge clk_i) begin
    alloc_result_t want;
    alloc_cmd_t    cmd;
    if (rst_ni) begin
      if (done_o) begin
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = grant_q.pop_front();
          if (slot_out_o !== want.slot)
            report_mismatch("slot_out", int'(slot_out_o), int'(want.slot));
          if (status_o !== want.status)
            report_mismatch("status", int'(status_o), int'(want.status));
          if (live_total_o !== want.live)
            report_mismatch("live_total", int'(live_total_o), int'(want.live));
          if (slots_used_o !== want.used)
            report_mismatch("slots_used", int'(slots_used_o), int'(want.used));
          if (free_total_o !== want.free)
            report_mismatch("free_total", int'(free_total_o), int'(want.free));
        end
      end
      if (start && !busy) begin
        cmd.kind = kind_i;
        cmd.slot = slot_in_i;
        allocate_step(cmd, want);
        grant_q = {grant_q, want};
        accepted_cnt++;
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic issue(input logic [1:0] kind, input int slot);
    alloc_cmd_t cmd;
    while (cmd_q.size() >= QUEUE_ROOM) @(posedge clk_i);
    cmd.kind = kind;
    cmd.slot = slot_t'(slot);
    cmd_q = {cmd_q, cmd};
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || accepted_cnt != queued_cnt || grant_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Picks a slot that is live in the shadow state, falling back to the last grant.
  function automatic int pick_live_slot();
    int s;
    if (live_cnt > 0 && water_mark > 0) begin
      for (int i = 0; i < 16; i++) begin
        s = $urandom_range(0, water_mark - 1);
        if (live_bits[s]) return s;
      end
    end
    return int'(last_grant);
  endfunction

  function automatic int pick_stacked_slot();
    if (freed_depth == 0) return pick_live_slot();
    if ($urandom_range(0, 1) == 0) return int'(freed_slots[freed_depth - 1]);
    return int'(freed_slots[$urandom_range(0, freed_depth - 1)]);
  endfunction

  // Mostly well-formed traffic: releases aim at live slots, updates stay near the
  // water mark or revive stacked slots, with a little noise mixed in.
  task automatic issue_random();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      issue(KIND_INSERT, $urandom_range(0, SLOTS - 1));
    end else if (r < 63) begin
      issue(KIND_RELEASE, pick_live_slot());
    end else if (r < 68) begin
      issue(KIND_RELEASE, $urandom_range(0, SLOTS - 1));
    end else if (r < 76) begin
      issue(KIND_RELEASE, pick_stacked_slot());
    end else if (r < 84) begin
      issue(KIND_UPDATE, pick_stacked_slot());
    end else if (r < 96) begin
      s = water_mark + $urandom_range(0, 3) - 2;
      if (s < 0) s = 0;
      if (s > SLOTS - 1) s = $urandom_range(0, SLOTS - 1);
      issue(KIND_UPDATE, s);
    end else if (r < 97) begin
      if ($urandom_range(0, 7) == 0) issue(KIND_UPDATE, $urandom_range(0, SLOTS - 1));
      else issue(KIND_UPDATE, pick_live_slot());
    end else begin
      issue(KIND_UNUSED, $urandom_range(0, SLOTS - 1));
    end
  endtask

  initial begin
    int idle_plan [4];
    int depth;
    idle_plan = '{0, 51, 6, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: grants, reuse, ignored release, revival, skip past the mark, no-op.
    issue(KIND_INSERT, 0);
    issue(KIND_INSERT, SLOTS - 1);
    issue(KIND_INSERT, 0);
    issue(KIND_RELEASE, 1);
    issue(KIND_RELEASE, 1);
    issue(KIND_INSERT, 0);
    issue(KIND_RELEASE, 2);
    issue(KIND_UPDATE, 2);
    issue(KIND_INSERT, 0);
    issue(KIND_RELEASE, 0);
    issue(KIND_RELEASE, 2);
    issue(KIND_UPDATE, 0);
    issue(KIND_UPDATE, 6);
    issue(KIND_RELEASE, 4);
    issue(KIND_INSERT, 0);
    issue(KIND_INSERT, 0);
    issue(KIND_INSERT, 0);
    issue(KIND_UNUSED, SLOTS - 1);
    issue(KIND_UNUSED, 0);
    issue(KIND_RELEASE, SLOTS - 1);
    issue(KIND_UPDATE, 0);
    wait_drained();

    // Random traffic under several sender idle rates, draining between phases.
    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      for (int i = 0; i < 260; i++) issue_random();
      wait_drained();
    end

    // Pool full: raise the mark to the top, empty the stack, then ask for more.
    sender_idle_pct = 6;
    issue(KIND_UPDATE, SLOTS - 1);
    wait_drained();
    depth = freed_depth;
    for (int i = 0; i < depth + 2; i++) issue(KIND_INSERT, $urandom_range(0, SLOTS - 1));
    wait_drained();

    // A few more inserts against the full pool, then some mixed traffic.
    for (int i = 0; i < 6; i++) issue(KIND_INSERT, 0);
    for (int i = 0; i < 40; i++) issue_random();
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
